>>> src/shfp_pkg.sv
`timescale 1ns / 1ps

package shfp_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 2048;

   localparam int unsigned LEN_W   = 16;
   localparam int unsigned IDX_W   = 11;
   localparam int unsigned PLEN_W  = 12;
   localparam int unsigned SUM_W   = 32;
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [7:0]  SYNC_FIRST      = 8'h40;
   localparam logic [7:0]  SYNC_SECOND     = 8'h54;
   localparam logic [7:0]  SERIAL_MOD_MASK = 8'h7F;
   localparam logic [15:0] CSR_RESET       = 16'd1;
   localparam int unsigned MODE_CHK_BIT    = 0;
   localparam int unsigned FLAG_OLD_SOURCE = 0;
   localparam int unsigned FLAG_SERIAL_GAP = 1;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_SRC_LO,
      PH_SRC_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SERIAL,
      PH_FEAT_LO,
      PH_FEAT_HI,
      PH_REQ,
      PH_MODE,
      PH_PAYLOAD,
      PH_SUM0,
      PH_SUM1,
      PH_SUM2,
      PH_SUM3
   } phase_type;

   typedef enum logic [3:0] {
      OP_HUNT,
      OP_SRC_LO,
      OP_SRC_HI,
      OP_LEN_LO,
      OP_LEN_HI,
      OP_SERIAL,
      OP_FEAT_LO,
      OP_FEAT_HI,
      OP_REQ,
      OP_MODE,
      OP_PAYLOAD,
      OP_SUM0,
      OP_SUM1,
      OP_SUM2,
      OP_SUM3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         data;
      logic [IDX_W-1:0]   index;
      logic               done;
   } q_item_type;

endpackage

>>> src/sync_header_frame_parser_top.sv
`timescale 1ns / 1ps

// Port group   Direction   Handshake                  Carries
// req_*        in          req_valid / req_stall      one received byte
// rsp_*        out         rsp_valid / rsp_stall      payload byte or frame close
// csr_*        in          csr_wr_en                  min_source_version
//
// One byte a cycle sustained while rsp_stall stays low; a result passes through a queue entry and the output register.
// The front sequencer, a two-entry queue and the back header/result stage each
// stall on their own; req_stall rises only when the queue is full.
// Reset is synchronous and clears the parse state, flags and csr (to 1).
// A stalled result holds while the queue keeps taking bytes until it is full.

module sync_header_frame_parser_top #(
   parameter int unsigned MAX_PAYLOAD = shfp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_payload,
   output logic [7:0]                  rsp_payload_byte,
   output logic [shfp_pkg::IDX_W-1:0]  rsp_payload_index,
   output logic                        rsp_frame_end,
   output logic [15:0]                 rsp_source_id,
   output logic [shfp_pkg::PLEN_W-1:0] rsp_payload_len,
   output logic [7:0]                  rsp_serial,
   output logic [15:0]                 rsp_feature_addr,
   output logic [7:0]                  rsp_request,
   output logic [7:0]                  rsp_mode_bits,
   output logic [1:0]                  rsp_status_flags,
   output logic [shfp_pkg::SUM_W-1:0]  rsp_checksum,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data
);
   import shfp_pkg::*;

   logic       take;
   logic       push;
   logic       pop;
   logic       q_full;
   logic       q_not_empty;
   q_item_type push_item;
   q_item_type head_item;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   shfp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .push     (push),
      .push_item(push_item)
   );

   shfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head_item(head_item)
   );

   shfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .item_valid       (q_not_empty),
      .item             (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_payload   (rsp_is_payload),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_source_id    (rsp_source_id),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_serial       (rsp_serial),
      .rsp_feature_addr (rsp_feature_addr),
      .rsp_request      (rsp_request),
      .rsp_mode_bits    (rsp_mode_bits),
      .rsp_status_flags (rsp_status_flags),
      .rsp_checksum     (rsp_checksum)
   );

endmodule

>>> src/shfp_front.sv
`timescale 1ns / 1ps

module shfp_front #(
   parameter int unsigned MAX_PAYLOAD = shfp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output logic                 push,
   output shfp_pkg::q_item_type push_item
);
   import shfp_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

   phase_type        phase_ff, phase_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_nxt;
   logic             chk_ff, chk_in;
   logic [LEN_W-1:0] full_len;

   assign full_len = {rx_byte, len_lo_ff};
   assign pos_nxt  = pos_ff + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
      len_lo_ff <= len_lo_in;
      len_ff    <= len_in;
      pos_ff    <= pos_in;
      chk_ff    <= chk_in;
   end

   always_comb begin
      phase_in        = phase_ff;
      len_lo_in       = len_lo_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      chk_in          = chk_ff;
      push            = 1'b0;
      push_item.op    = OP_HUNT;
      push_item.data  = rx_byte;
      push_item.index = '0;
      push_item.done  = 1'b0;
      if (take) begin
         push = 1'b1;
         case (phase_ff)
            PH_HUNT: begin
               push_item.op = OP_HUNT;
               if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               push     = 1'b0;
               phase_in = (rx_byte == SYNC_SECOND) ? PH_SRC_LO : PH_HUNT;
            end
            PH_SRC_LO: begin
               push_item.op = OP_SRC_LO;
               phase_in     = PH_SRC_HI;
            end
            PH_SRC_HI: begin
               push_item.op = OP_SRC_HI;
               phase_in     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               push_item.op = OP_LEN_LO;
               len_lo_in    = rx_byte;
               phase_in     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               push_item.op = OP_LEN_HI;
               len_in       = POS_W'(full_len);
               // drop oversized frames
               phase_in     = (full_len > LEN_W'(MAX_PAYLOAD)) ? PH_HUNT : PH_SERIAL;
            end
            PH_SERIAL: begin
               push_item.op = OP_SERIAL;
               phase_in     = PH_FEAT_LO;
            end
            PH_FEAT_LO: begin
               push_item.op = OP_FEAT_LO;
               phase_in     = PH_FEAT_HI;
            end
            PH_FEAT_HI: begin
               push_item.op = OP_FEAT_HI;
               phase_in     = PH_REQ;
            end
            PH_REQ: begin
               push_item.op = OP_REQ;
               phase_in     = PH_MODE;
            end
            PH_MODE: begin
               push_item.op = OP_MODE;
               pos_in       = '0;
               chk_in       = rx_byte[MODE_CHK_BIT];
               if (len_ff != '0) begin
                  phase_in = PH_PAYLOAD;
               end else if (rx_byte[MODE_CHK_BIT]) begin
                  phase_in = PH_SUM0;
               end else begin
                  phase_in       = PH_HUNT;
                  push_item.done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               push_item.op    = OP_PAYLOAD;
               push_item.index = IDX_W'(pos_ff);
               pos_in          = pos_nxt;
               if (pos_nxt >= len_ff) begin
                  if (chk_ff) begin
                     phase_in = PH_SUM0;
                  end else begin
                     phase_in       = PH_HUNT;
                     push_item.done = 1'b1;
                  end
               end
            end
            PH_SUM0: begin
               push_item.op = OP_SUM0;
               phase_in     = PH_SUM1;
            end
            PH_SUM1: begin
               push_item.op = OP_SUM1;
               phase_in     = PH_SUM2;
            end
            PH_SUM2: begin
               push_item.op = OP_SUM2;
               phase_in     = PH_SUM3;
            end
            PH_SUM3: begin
               push_item.op   = OP_SUM3;
               push_item.done = 1'b1;
               phase_in       = PH_HUNT;
            end
            default: begin
               push     = 1'b0;
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (pos_ff < len_ff))
      else $error("payload position beyond frame length");

   a_sync2_no_push: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYNC2) |-> !push)
      else $error("second sync byte forwarded to back end");

endmodule

>>> src/shfp_queue.sv
`timescale 1ns / 1ps

module shfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  shfp_pkg::q_item_type push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output shfp_pkg::q_item_type head_item
);
   import shfp_pkg::*;

   q_item_type        entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QDEPTH - 1)) r = '0;
      else r = p + QPTR_W'(1);
      return r;
   endfunction

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

>>> src/shfp_back.sv
`timescale 1ns / 1ps

module shfp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data,
   input  logic                        item_valid,
   input  shfp_pkg::q_item_type        item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_payload,
   output logic [7:0]                  rsp_payload_byte,
   output logic [shfp_pkg::IDX_W-1:0]  rsp_payload_index,
   output logic                        rsp_frame_end,
   output logic [15:0]                 rsp_source_id,
   output logic [shfp_pkg::PLEN_W-1:0] rsp_payload_len,
   output logic [7:0]                  rsp_serial,
   output logic [15:0]                 rsp_feature_addr,
   output logic [7:0]                  rsp_request,
   output logic [7:0]                  rsp_mode_bits,
   output logic [1:0]                  rsp_status_flags,
   output logic [shfp_pkg::SUM_W-1:0]  rsp_checksum
);
   import shfp_pkg::*;

   logic [15:0]       csr_min_ff;
   logic [15:0]       src_ff, src_in;
   logic [PLEN_W-1:0] len_ff, len_in;
   logic [7:0]        serial_ff, serial_in;
   logic [15:0]       feat_ff, feat_in;
   logic [7:0]        req_ff, req_in;
   logic [7:0]        mode_ff, mode_in;
   logic [1:0]        flags_ff, flags_in;
   logic [23:0]       sum_ff, sum_in;
   logic [7:0]        prev_ff, prev_in;
   logic              first_ff, first_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_isp_ff, out_isp_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_done_ff, out_done_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;
   logic              emit;
   logic [15:0]       src_full;

   assign pop      = item_valid && (!out_valid_ff || !rsp_stall);
   assign src_full = {item.data, src_ff[7:0]};

   always_comb begin
      src_in      = src_ff;
      len_in      = len_ff;
      serial_in   = serial_ff;
      feat_in     = feat_ff;
      req_in      = req_ff;
      mode_in     = mode_ff;
      flags_in    = flags_ff;
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      first_in    = first_ff;
      emit        = 1'b0;
      out_isp_in  = 1'b0;
      out_byte_in = '0;
      out_idx_in  = '0;
      out_done_in = item.done;
      out_sum_in  = '0;
      if (pop) begin
         case (item.op)
            OP_HUNT: flags_in = '0;
            OP_SRC_LO: src_in = {src_ff[15:8], item.data};
            OP_SRC_HI: begin
               src_in = src_full;
               if (src_full < csr_min_ff) flags_in[FLAG_OLD_SOURCE] = 1'b1;
            end
            OP_LEN_LO: len_in = {len_ff[PLEN_W-1:8], item.data};
            OP_LEN_HI: len_in = {item.data[PLEN_W-9:0], len_ff[7:0]};
            OP_SERIAL: begin
               serial_in = item.data;
               prev_in   = item.data;
               if (first_ff) begin
                  first_in = 1'b0;
               end else if (item.data != ((prev_ff + 8'd1) & SERIAL_MOD_MASK)) begin
                  flags_in[FLAG_SERIAL_GAP] = 1'b1;
               end
            end
            OP_FEAT_LO: feat_in = {feat_ff[15:8], item.data};
            OP_FEAT_HI: feat_in = {item.data, feat_ff[7:0]};
            OP_REQ: req_in = item.data;
            OP_MODE: begin
               mode_in = item.data;
               emit    = item.done;
            end
            OP_PAYLOAD: begin
               emit        = 1'b1;
               out_isp_in  = 1'b1;
               out_byte_in = item.data;
               out_idx_in  = item.index;
            end
            OP_SUM0: sum_in = {16'd0, item.data};
            OP_SUM1: sum_in[15:8] = item.data;
            OP_SUM2: sum_in[23:16] = item.data;
            OP_SUM3: begin
               emit        = 1'b1;
               out_done_in = 1'b1;
               out_sum_in  = {item.data, sum_ff};
            end
            default: emit = 1'b0;
         endcase
      end
      if (emit) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_min_ff   <= CSR_RESET;
         flags_ff     <= '0;
         first_ff     <= 1'b1;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) csr_min_ff <= csr_wr_data;
         flags_ff     <= flags_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
      src_ff    <= src_in;
      len_ff    <= len_in;
      serial_ff <= serial_in;
      feat_ff   <= feat_in;
      req_ff    <= req_in;
      mode_ff   <= mode_in;
      sum_ff    <= sum_in;
      if (emit) begin
         out_isp_ff  <= out_isp_in;
         out_byte_ff <= out_byte_in;
         out_idx_ff  <= out_idx_in;
         out_done_ff <= out_done_in;
         out_sum_ff  <= out_sum_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_payload    = out_isp_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_payload_index = out_idx_ff;
   assign rsp_frame_end     = out_done_ff;
   assign rsp_source_id     = src_ff;
   assign rsp_payload_len   = len_ff;
   assign rsp_serial        = serial_ff;
   assign rsp_feature_addr  = feat_ff;
   assign rsp_request       = req_ff;
   assign rsp_mode_bits     = mode_ff;
   assign rsp_status_flags  = flags_ff;
   assign rsp_checksum      = out_sum_ff;

   a_trailer_closes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_isp_ff) |-> out_done_ff)
      else $error("non-payload word does not close a frame");

   a_trailer_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_isp_ff) |-> (out_byte_ff == '0 && out_idx_ff == '0))
      else $error("non-payload word carries payload data");

   a_sum_on_close: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sum_ff != '0) |-> (out_done_ff && !out_isp_ff))
      else $error("checksum reported outside a closing word");

   a_pop_only_free: assert property (@(posedge clock) disable iff (reset)
      (emit && out_valid_ff) |-> !rsp_stall)
      else $error("result overwritten while stalled");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import shfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct {
      logic              is_payload;
      logic [7:0]        payload_byte;
      logic [IDX_W-1:0]  payload_index;
      logic              frame_end;
      logic [15:0]       source_id;
      logic [PLEN_W-1:0] payload_len;
      logic [7:0]        serial;
      logic [15:0]       feature_addr;
      logic [7:0]        request;
      logic [7:0]        mode_bits;
      logic [1:0]        status_flags;
      logic [SUM_W-1:0]  checksum;
   } parse_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_is_payload;
   logic [7:0]          rsp_payload_byte;
   logic [IDX_W-1:0]    rsp_payload_index;
   logic                rsp_frame_end;
   logic [15:0]         rsp_source_id;
   logic [PLEN_W-1:0]   rsp_payload_len;
   logic [7:0]          rsp_serial;
   logic [15:0]         rsp_feature_addr;
   logic [7:0]          rsp_request;
   logic [7:0]          rsp_mode_bits;
   logic [1:0]          rsp_status_flags;
   logic [SUM_W-1:0]    rsp_checksum;
   logic                csr_wr_en = 1'b0;
   logic [15:0]         csr_wr_data = 16'h0000;

   logic [7:0]          rx_pending[$];
   parse_result_type    due_results[$];
   bit                  byte_taken = 1'b0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int unsigned         hold_left = 0;
   int unsigned         cycle_count = 0;
   int                  errors = 0;
   int                  frame_bytes = 0;
   logic [7:0]          gen_serial = 8'h00;
   logic [15:0]         gen_min = CSR_RESET;

   // parser state as the block should hold it
   phase_type           ph = PH_HUNT;
   int unsigned         pos = 0;
   logic [15:0]         hdr_src = '0;
   logic [15:0]         hdr_len = '0;
   logic [7:0]          hdr_ser = '0;
   logic [15:0]         hdr_feat = '0;
   logic [7:0]          hdr_req = '0;
   logic [7:0]          hdr_mode = '0;
   logic [1:0]          flags = '0;
   logic [31:0]         sum_acc = '0;
   logic [7:0]          prev_ser = '0;
   bit                  first_frame = 1'b1;
   logic [15:0]         min_ver = CSR_RESET;

   sync_header_frame_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_payload    (rsp_is_payload),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_source_id     (rsp_source_id),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_serial        (rsp_serial),
      .rsp_feature_addr  (rsp_feature_addr),
      .rsp_request       (rsp_request),
      .rsp_mode_bits     (rsp_mode_bits),
      .rsp_status_flags  (rsp_status_flags),
      .rsp_checksum      (rsp_checksum),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 100) begin
         $display("ERROR %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      end
      errors++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   function automatic void post_result(input logic isp, input logic [7:0] pb,
                                       input logic [IDX_W-1:0] idx, input logic done,
                                       input logic [31:0] sum);
      parse_result_type r;
      r.is_payload    = isp;
      r.payload_byte  = pb;
      r.payload_index = idx;
      r.frame_end     = done;
      r.source_id     = hdr_src;
      r.payload_len   = hdr_len[PLEN_W-1:0];
      r.serial        = hdr_ser;
      r.feature_addr  = hdr_feat;
      r.request       = hdr_req;
      r.mode_bits     = hdr_mode;
      r.status_flags  = flags;
      r.checksum      = sum;
      due_results.push_back(r);
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] b);
      logic [IDX_W-1:0] idx;
      case (ph)
         PH_HUNT: begin
            flags = '0;
            if (b == SYNC_FIRST) ph = PH_SYNC2;
         end
         PH_SYNC2: ph = (b == SYNC_SECOND) ? PH_SRC_LO : PH_HUNT;
         PH_SRC_LO: begin
            hdr_src = {8'h00, b};
            ph = PH_SRC_HI;
         end
         PH_SRC_HI: begin
            hdr_src = {b, hdr_src[7:0]};
            if (hdr_src < min_ver) flags[FLAG_OLD_SOURCE] = 1'b1;
            ph = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            hdr_len = {8'h00, b};
            ph = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            hdr_len = {b, hdr_len[7:0]};
            ph = (hdr_len > MAX_PAYLOAD_DEF) ? PH_HUNT : PH_SERIAL;
         end
         PH_SERIAL: begin
            hdr_ser = b;
            if (first_frame) begin
               first_frame = 1'b0;
            end else if (b != ((prev_ser + 8'd1) & SERIAL_MOD_MASK)) begin
               flags[FLAG_SERIAL_GAP] = 1'b1;
            end
            prev_ser = b;
            ph = PH_FEAT_LO;
         end
         PH_FEAT_LO: begin
            hdr_feat = {8'h00, b};
            ph = PH_FEAT_HI;
         end
         PH_FEAT_HI: begin
            hdr_feat = {b, hdr_feat[7:0]};
            ph = PH_REQ;
         end
         PH_REQ: begin
            hdr_req = b;
            ph = PH_MODE;
         end
         PH_MODE: begin
            hdr_mode = b;
            pos = 0;
            if (hdr_len > 0) begin
               ph = PH_PAYLOAD;
            end else if (hdr_mode[MODE_CHK_BIT]) begin
               ph = PH_SUM0;
            end else begin
               ph = PH_HUNT;
               post_result(1'b0, 8'h00, '0, 1'b1, '0);
            end
         end
         PH_PAYLOAD: begin
            idx = pos[IDX_W-1:0];
            pos = pos + 1;
            if (pos >= hdr_len) begin
               ph = hdr_mode[MODE_CHK_BIT] ? PH_SUM0 : PH_HUNT;
               post_result(1'b1, b, idx, !hdr_mode[MODE_CHK_BIT], '0);
            end else begin
               post_result(1'b1, b, idx, 1'b0, '0);
            end
         end
         PH_SUM0: begin
            sum_acc = {24'h0, b};
            ph = PH_SUM1;
         end
         PH_SUM1: begin
            sum_acc[15:8] = b;
            ph = PH_SUM2;
         end
         PH_SUM2: begin
            sum_acc[23:16] = b;
            ph = PH_SUM3;
         end
         default: begin
            sum_acc[31:24] = b;
            ph = PH_HUNT;
            post_result(1'b0, 8'h00, '0, 1'b1, sum_acc);
         end
      endcase
   endfunction

   // present the next word at the falling edge, hold it until taken
   always @(negedge clock) begin
      if (!req_valid || byte_taken) begin
         if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      byte_taken = !reset && req_valid && !req_stall;
      if (byte_taken) parse_rx_byte(req_rx_byte);
   end

   always @(posedge clock) begin : watch_results
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with none due", 32'h1, 32'h0);
         end else begin
            want = due_results.pop_front();
            check_field("is_payload", rsp_is_payload, want.is_payload);
            check_field("payload_byte", rsp_payload_byte, want.payload_byte);
            check_field("payload_index", rsp_payload_index, want.payload_index);
            check_field("frame_end", rsp_frame_end, want.frame_end);
            check_field("source_id", rsp_source_id, want.source_id);
            check_field("payload_len", rsp_payload_len, want.payload_len);
            check_field("serial", rsp_serial, want.serial);
            check_field("feature_addr", rsp_feature_addr, want.feature_addr);
            check_field("request", rsp_request, want.request);
            check_field("mode_bits", rsp_mode_bits, want.mode_bits);
            check_field("status_flags", rsp_status_flags, want.status_flags);
            check_field("checksum", rsp_checksum, want.checksum);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_frame(input logic [15:0] src, input logic [15:0] len,
                              input logic [7:0] ser, input logic [15:0] feat,
                              input logic [7:0] rq, input logic [7:0] md);
      int start;
      start = rx_pending.size();
      rx_pending.push_back(SYNC_FIRST);
      rx_pending.push_back(SYNC_SECOND);
      rx_pending.push_back(src[7:0]);
      rx_pending.push_back(src[15:8]);
      rx_pending.push_back(len[7:0]);
      rx_pending.push_back(len[15:8]);
      if (len <= MAX_PAYLOAD_DEF) begin
         gen_serial = ser;
         rx_pending.push_back(ser);
         rx_pending.push_back(feat[7:0]);
         rx_pending.push_back(feat[15:8]);
         rx_pending.push_back(rq);
         rx_pending.push_back(md);
         repeat (len) rx_pending.push_back(8'($urandom_range(255)));
         if (md[MODE_CHK_BIT]) repeat (4) rx_pending.push_back(8'($urandom_range(255)));
      end
      frame_bytes += rx_pending.size() - start;
   endtask

   task automatic queue_random_frame();
      logic [15:0] src;
      logic [15:0] len;
      logic [7:0]  ser;
      int          r;
      r = $urandom_range(9);
      src = (r == 0) ? 16'h0000 : (r == 1) ? gen_min - 16'd1 : (r == 2) ? gen_min :
            (r == 3) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
      r = $urandom_range(99);
      len = (r < 18) ? 16'd0 : (r < 88) ? 16'($urandom_range(1, 8)) :
            (r < 98) ? 16'($urandom_range(9, 40)) : 16'($urandom_range(41, 200));
      ser = ($urandom_range(9) < 8) ? ((gen_serial + 8'd1) & SERIAL_MOD_MASK)
                                    : 8'($urandom_range(255));
      queue_frame(src, len, ser, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
   endtask

   task automatic queue_noise();
      logic [15:0] len;
      case ($urandom_range(3))
         0: repeat ($urandom_range(1, 6)) rx_pending.push_back(8'($urandom_range(255)));
         1: begin
            rx_pending.push_back(SYNC_FIRST);
            rx_pending.push_back(8'($urandom_range(255)));
         end
         2: begin
            rx_pending.push_back(SYNC_FIRST);
            rx_pending.push_back(SYNC_FIRST);
            rx_pending.push_back(SYNC_SECOND);
         end
         default: begin
            len = 16'($urandom_range(MAX_PAYLOAD_DEF + 1, 16'hFFFF));
            rx_pending.push_back(SYNC_FIRST);
            rx_pending.push_back(SYNC_SECOND);
            rx_pending.push_back(8'($urandom_range(255)));
            rx_pending.push_back(8'($urandom_range(255)));
            rx_pending.push_back(len[7:0]);
            rx_pending.push_back(len[15:8]);
         end
      endcase
   endtask

   task automatic queue_traffic(input int n);
      int start;
      start = frame_bytes;
      while (frame_bytes - start < n) begin
         if ($urandom_range(99) < 80) queue_random_frame();
         else queue_noise();
      end
   endtask

   task automatic drain();
      while (rx_pending.size() != 0 || req_valid || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic set_min_version(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      min_ver = v;
      gen_min = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bad second sync, a payload frame with checksum, an oversized header
      rx_pending.push_back(SYNC_FIRST);
      rx_pending.push_back(SYNC_FIRST);
      rx_pending.push_back(SYNC_SECOND);
      queue_frame(16'h0000, 16'h0001, 8'hFF, 16'hFFFF, 8'h00, 8'hFF);
      rx_pending.push_back(SYNC_FIRST);
      rx_pending.push_back(SYNC_SECOND);
      rx_pending.push_back(8'hFF);
      rx_pending.push_back(8'hFF);
      rx_pending.push_back(8'h01);
      rx_pending.push_back(8'h08);
      drain();

      set_min_version(16'h0000);
      queue_frame(16'hFFFF, 16'h0100, (gen_serial + 8'd1) & SERIAL_MOD_MASK,
                  16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)), 8'h01);
      @(negedge clock);
      hold_left <= 400;
      @(posedge clock);
      queue_traffic(320);
      drain();

      set_min_version(16'hFFFF);
      send_idle_pct = 60;
      queue_traffic(320);
      drain();

      set_min_version(16'($urandom_range(16'hFFFF)));
      send_idle_pct = 0;
      stall_pct = 60;
      queue_traffic(320);
      drain();

      set_min_version(16'($urandom_range(300)));
      send_idle_pct = 29;
      stall_pct = 29;
      queue_traffic(320);
      drain();

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sync_header_frame_parser_top.f
src/shfp_pkg.sv
src/shfp_front.sv
src/shfp_queue.sv
src/shfp_back.sv
src/sync_header_frame_parser_top.sv
bench/tb.sv
